FILE: hw/rtl/crtt_pkg.sv
// Shared types and codes for the command retry/timeout table.
// Request, response and status encodings; no dependencies.
package crtt_pkg;

   typedef enum logic [1:0] {
      OP_NEW   = 2'd0,
      OP_TICK  = 2'd1,
      OP_POLL  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RSP_QUEUED  = 3'd0,
      RSP_FULL    = 3'd1,
      RSP_REPORT  = 3'd2,
      RSP_CLEARED = 3'd3,
      RSP_EMPTY   = 3'd4
   } rsp_kind_type;

   typedef enum logic [1:0] {
      ST_WAITING  = 2'd0,
      ST_RETRYING = 2'd1,
      ST_TIMEOUT  = 2'd2
   } entry_state_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } seq_state_type;

   localparam logic CSR_RETRY_COUNT     = 1'b0;
   localparam logic CSR_TIMEOUT_SECONDS = 1'b1;

   localparam logic [3:0] RETRY_COUNT_RESET     = 4'd3;
   localparam logic [7:0] TIMEOUT_SECONDS_RESET = 8'd5;

   typedef struct packed {
      op_type     op;
      logic [1:0] command_code;
   } req_word_type;

   typedef struct packed {
      rsp_kind_type    kind;
      logic [15:0]     sequence_number;
      logic [1:0]      entry_command;
      logic [3:0]      retries_remaining;
      logic [7:0]      seconds_remaining;
      logic [7:0]      entry_timeout;
      entry_state_type entry_status;
      logic [4:0]      cleared_count;
      logic            last;
   } rsp_word_type;

endpackage

FILE: hw/rtl/crtt_entry_alu.sv
// Shared entry update unit: tick aging, poll retry/timeout and seconds left.
// Depends on crtt_pkg.
module crtt_entry_alu import crtt_pkg::*; #(
   parameter int AGE_BITS = 8
) (
   input  logic                is_poll,
   input  logic [AGE_BITS-1:0] age,
   input  logic [7:0]          timeout,
   input  logic [3:0]          retries,
   input  entry_state_type     status,
   output logic [AGE_BITS-1:0] age_next,
   output logic [3:0]          retries_next,
   output entry_state_type     status_next,
   output logic [7:0]          secs
);

   localparam int CMP_W = (AGE_BITS > 8) ? AGE_BITS : 8;

   logic [CMP_W-1:0] age_ext;
   logic [CMP_W-1:0] tmo_ext;
   logic [CMP_W-1:0] age_next_ext;
   logic [CMP_W-1:0] diff;

   assign age_ext = CMP_W'(age);
   assign tmo_ext = CMP_W'(timeout);

   always_comb begin
      age_next     = age;
      retries_next = retries;
      status_next  = status;
      if (!is_poll) begin
         if (age != '1) begin
            age_next = age + AGE_BITS'(1);
         end
      end else begin
         case (status)
            ST_TIMEOUT: begin
            end
            default: begin
               if (age_ext >= tmo_ext) begin
                  if (retries != 4'd0) begin
                     retries_next = retries - 4'd1;
                     age_next     = '0;
                     status_next  = ST_RETRYING;
                  end else begin
                     status_next = ST_TIMEOUT;
                  end
               end else if (status == ST_RETRYING) begin
                  status_next = ST_WAITING;
               end
            end
         endcase
      end
   end

   assign age_next_ext = CMP_W'(age_next);
   assign diff         = tmo_ext - age_next_ext;
   assign secs         = (tmo_ext > age_next_ext) ? diff[7:0] : 8'd0;

endmodule

FILE: hw/rtl/crtt_table.sv
// Entry store: one write port, one registered read port.
// No dependencies.
module crtt_table #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 40
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/command_retry_timeout_table.sv
// Top level: command retry/timeout table with scan sequencer and CSRs.
// Depends on crtt_pkg, crtt_table, crtt_entry_alu.
//
//   channel | ports                           | handshake
//   --------+---------------------------------+------------------------------
//   request | start, busy, req_word           | taken when start & !busy
//   result  | rsp_valid, rsp_word             | one-cycle strobe, no stall
//   config  | csr_write_en, csr_index, csr_data | write when csr_write_en
//
// New, clear and poll on an empty table: taken without leaving idle, word next cycle.
// Tick on an empty table: taken without leaving idle, no word.
// Tick and poll otherwise walk the table one entry per cycle through the
// store's read port, staying busy until the last entry is written back.
// Reset empties the table and zeroes the sequence counter; stored entries
// are left as they are and only entries below the count are ever read.
// Words go out one per cycle during a poll; the receiver cannot stall.
module command_retry_timeout_table import crtt_pkg::*; #(
   parameter int TABLE_DEPTH   = 16,
   parameter int SEQUENCE_BITS = 16,
   parameter int AGE_BITS      = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         csr_write_en,
   input  logic         csr_index,
   input  logic [7:0]   csr_data
);

   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = SEQUENCE_BITS + 2 + 4 + AGE_BITS + 8 + 2;

   seq_state_type          state_ff, state_in;
   logic                   poll_ff, poll_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]       proc_idx_ff, proc_idx_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SEQUENCE_BITS-1:0] seq_ff, seq_in;
   logic [3:0]             retry_cfg_ff, retry_cfg_in;
   logic [7:0]             tmo_cfg_ff, tmo_cfg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic                   accept;
   logic                   full;
   logic                   issue;
   logic                   last_proc;
   logic                   scan_op;

   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [ENTRY_W-1:0]     mem_wdata;
   logic [ENTRY_W-1:0]     mem_rdata;

   logic [SEQUENCE_BITS-1:0] rd_seq;
   logic [1:0]             rd_code;
   logic [3:0]             rd_retries;
   logic [AGE_BITS-1:0]    rd_age;
   logic [7:0]             rd_tmo;
   logic [1:0]             rd_state_bits;

   logic [AGE_BITS-1:0]    alu_age;
   logic [3:0]             alu_retries;
   entry_state_type        alu_status;
   logic [7:0]             alu_secs;

   assign busy      = (state_ff == S_SCAN);
   assign accept    = start && !busy;
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign issue     = (state_ff == S_SCAN) && (rd_idx_ff < count_ff);
   assign last_proc = rd_pend_ff && (CNT_W'(proc_idx_ff + CNT_W'(1)) == count_ff);
   assign scan_op   = (req_word.op == OP_TICK) || (req_word.op == OP_POLL);

   assign {rd_seq, rd_code, rd_retries, rd_age, rd_tmo, rd_state_bits} = mem_rdata;

   crtt_table #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IDX_W),
      .DATA_W (ENTRY_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (mem_rdata)
   );

   crtt_entry_alu #(
      .AGE_BITS (AGE_BITS)
   ) u_alu (
      .is_poll      (poll_ff),
      .age          (rd_age),
      .timeout      (rd_tmo),
      .retries      (rd_retries),
      .status       (entry_state_type'(rd_state_bits)),
      .age_next     (alu_age),
      .retries_next (alu_retries),
      .status_next  (alu_status),
      .secs         (alu_secs)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && scan_op && (count_ff != '0)) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (last_proc) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      poll_in      = poll_ff;
      rd_idx_in    = rd_idx_ff;
      proc_idx_in  = proc_idx_ff;
      rd_pend_in   = 1'b0;
      count_in     = count_ff;
      seq_in       = seq_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = '0;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[IDX_W-1:0];
      mem_wdata    = {SEQUENCE_BITS'(seq_ff + SEQUENCE_BITS'(1)), req_word.command_code,
                      retry_cfg_ff, AGE_BITS'(0), tmo_cfg_ff, ST_WAITING};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_word_in.last = 1'b1;
               unique case (req_word.op)
                  OP_NEW: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_word_in.kind = RSP_FULL;
                     end else begin
                        mem_we                      = 1'b1;
                        seq_in                      = seq_ff + SEQUENCE_BITS'(1);
                        count_in                    = count_ff + CNT_W'(1);
                        rsp_word_in.kind            = RSP_QUEUED;
                        rsp_word_in.sequence_number = 16'(seq_in);
                     end
                  end
                  OP_TICK, OP_POLL: begin
                     poll_in   = (req_word.op == OP_POLL);
                     rd_idx_in = '0;
                     if ((count_ff == '0) && (req_word.op == OP_POLL)) begin
                        rsp_valid_in     = 1'b1;
                        rsp_word_in.kind = RSP_EMPTY;
                     end
                  end
                  OP_CLEAR: begin
                     rsp_valid_in              = 1'b1;
                     rsp_word_in.kind          = RSP_CLEARED;
                     rsp_word_in.cleared_count = 5'(count_ff);
                     count_in                  = '0;
                     seq_in                    = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue) begin
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
               proc_idx_in = rd_idx_ff;
               rd_pend_in  = 1'b1;
            end
            if (rd_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = proc_idx_ff[IDX_W-1:0];
               mem_wdata = {rd_seq, rd_code, alu_retries, alu_age, rd_tmo, alu_status};
               if (poll_ff) begin
                  rsp_valid_in                  = 1'b1;
                  rsp_word_in.kind              = RSP_REPORT;
                  rsp_word_in.sequence_number   = 16'(rd_seq);
                  rsp_word_in.entry_command     = rd_code;
                  rsp_word_in.retries_remaining = alu_retries;
                  rsp_word_in.seconds_remaining = alu_secs;
                  rsp_word_in.entry_timeout     = rd_tmo;
                  rsp_word_in.entry_status      = alu_status;
                  rsp_word_in.last              = last_proc;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // config writes
   always_comb begin
      retry_cfg_in = retry_cfg_ff;
      tmo_cfg_in   = tmo_cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_RETRY_COUNT:     retry_cfg_in = csr_data[3:0];
            CSR_TIMEOUT_SECONDS: tmo_cfg_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_pend_ff   <= 1'b0;
         count_ff     <= '0;
         seq_ff       <= '0;
         retry_cfg_ff <= RETRY_COUNT_RESET;
         tmo_cfg_ff   <= TIMEOUT_SECONDS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         count_ff     <= count_in;
         seq_ff       <= seq_in;
         retry_cfg_ff <= retry_cfg_in;
         tmo_cfg_ff   <= tmo_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      poll_ff     <= poll_in;
      rd_idx_ff   <= rd_idx_in;
      proc_idx_ff <= proc_idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: hw/rtl/crtt_checker.sv
// Port-level checks for the command retry/timeout table, with bind.
// Depends on crtt_pkg and command_retry_timeout_table.
module crtt_checker import crtt_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_word_type req_word,
   input logic         rsp_valid,
   input rsp_word_type rsp_word
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("word or busy after reset");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_word.op == OP_NEW || req_word.op == OP_CLEAR)
      |=> rsp_valid && rsp_word.last)
      else $error("missing single word");

   a_tick_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_word.op == OP_TICK |=> !rsp_valid)
      else $error("word after tick");

   a_report_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind == RSP_REPORT && !rsp_word.last |-> busy)
      else $error("poll ended before last report");

   a_lone_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.kind == RSP_QUEUED || rsp_word.kind == RSP_FULL ||
                    rsp_word.kind == RSP_CLEARED || rsp_word.kind == RSP_EMPTY)
      |-> rsp_word.last && !busy)
      else $error("single word not marked last");

endmodule

bind command_retry_timeout_table crtt_checker u_crtt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
